// ===== hw/rtl/kconv_pkg.sv =====
// Shared types and constants of the clamped 3x3 kernel convolution core.
package kconv_pkg;

	localparam int MAX_WIDTH    = 1024;
	localparam int MAX_CHANNELS = 4;
	localparam int COEFF_BITS   = 5;
	localparam int TAPS         = 9;

	localparam int PIX_W    = 8;
	localparam int WIDTH_W  = 11;
	localparam int HEIGHT_W = 16;
	localparam int CHAN_W   = 3;
	localparam int KERNEL_W = TAPS * COEFF_BITS;
	localparam int PEND_W   = 13;
	localparam int CFG_IDX_W = 2;

	localparam int XW     = $clog2(MAX_WIDTH);
	localparam int CW     = $clog2(MAX_CHANNELS);
	localparam int ADDR_W = XW + CW;
	localparam int BANK_DEPTH = MAX_WIDTH * MAX_CHANNELS;

	localparam int PROD_W = PIX_W + 1 + COEFF_BITS;
	localparam int SUM_W  = PROD_W + 4;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam int PIX_MAX = 255;
	localparam int BORDER  = 2;
	localparam int MIN_DIM = 3;

	localparam logic [WIDTH_W-1:0]  RST_WIDTH    = WIDTH_W'(MAX_WIDTH);
	localparam logic [HEIGHT_W-1:0] RST_HEIGHT   = 16'd480;
	localparam logic [CHAN_W-1:0]   RST_CHANNELS = 3'd1;
	localparam logic [KERNEL_W-1:0] RST_KERNEL   = 45'd34121365650465;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH    = 2'd0,
		REG_HEIGHT   = 2'd1,
		REG_CHANNELS = 2'd2,
		REG_KERNEL   = 2'd3
	} kconv_reg_t;

	// Frame geometry, already limited to the supported range.
	typedef struct packed {
		logic [WIDTH_W-1:0]  width;
		logic [HEIGHT_W-1:0] height;
		logic [CHAN_W-1:0]   channels;
	} kconv_frame_cfg_t;

	// One classified item handed from the front to the back.
	typedef struct packed {
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] bot;
		logic [CW-1:0]    chan;
		logic             emit;
		logic             interior;
		logic             last;
	} kconv_item_t;

endpackage

// ===== hw/rtl/kconv_front.sv =====
// Front end: raster position tracking, item classification and the two line buffer banks.
module kconv_front
	import kconv_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pix_valid,
	output logic                 pix_ready,
	input  logic [PIX_W-1:0]     pixel_value,
	input  logic                 flush,
	input  kconv_frame_cfg_t     frame_cfg,
	input  logic [FIFO_AW:0]     fifo_level,
	output logic                 push,
	output kconv_item_t          push_item
);

	logic [XW-1:0]       col_q;
	logic [HEIGHT_W-1:0] row_q;
	logic [CW-1:0]       chan_q;
	logic [PEND_W-1:0]   pend_q;

	logic [PIX_W-1:0] line0_q [BANK_DEPTH];
	logic [PIX_W-1:0] line1_q [BANK_DEPTH];

	logic              s1_valid_q;
	logic [PIX_W-1:0]  rd0_s1;
	logic [PIX_W-1:0]  rd1_s1;
	logic [PIX_W-1:0]  bot_s1;
	logic              top_en_s1;
	logic              mid_en_s1;
	logic              mid_bank_s1;
	logic [CW-1:0]     chan_s1;
	logic              emit_s1;
	logic              interior_s1;
	logic              last_s1;

	logic                accept;
	logic                frame_done;
	logic                flush_go;
	logic                restart;
	logic [XW-1:0]       x_cur;
	logic [HEIGHT_W-1:0] y_cur;
	logic [CW-1:0]       c_cur;
	logic [CHAN_W-1:0]   chan_inc;
	logic [WIDTH_W-1:0]  col_inc;
	logic [HEIGHT_W:0]   row_inc;
	logic                chan_wrap;
	logic                col_wrap;
	logic                row_end;
	logic [CW-1:0]       chan_n;
	logic [XW-1:0]       col_n;
	logic [HEIGHT_W-1:0] row_n;
	logic [PEND_W-1:0]   pend_full;
	logic                emit_px;
	logic                interior_px;
	logic [ADDR_W-1:0]   addr;
	logic                wr_en;

	// Room is reserved for the item held in the read stage.
	assign pix_ready = ((fifo_level + (FIFO_AW+1)'(s1_valid_q)) < (FIFO_AW+1)'(FIFO_DEPTH));
	assign accept    = pix_valid && pix_ready;

	always_comb begin
		frame_done = row_q >= frame_cfg.height;
		flush_go   = flush && frame_done && (pend_q != '0);
		// A pixel that arrives after the frame end starts a new frame at the origin.
		restart    = !flush && frame_done;
		x_cur      = restart ? '0 : col_q;
		y_cur      = restart ? '0 : row_q;
		c_cur      = restart ? '0 : chan_q;
		chan_inc   = CHAN_W'(c_cur) + 1'b1;
		col_inc    = WIDTH_W'(x_cur) + 1'b1;
		row_inc    = (HEIGHT_W+1)'(y_cur) + 1'b1;
		chan_wrap  = chan_inc >= frame_cfg.channels;
		col_wrap   = chan_wrap && (col_inc >= frame_cfg.width);
		row_end    = col_wrap && (row_inc >= (HEIGHT_W+1)'(frame_cfg.height));
		chan_n     = chan_wrap ? '0 : chan_inc[CW-1:0];
		col_n      = col_wrap ? '0 : (chan_wrap ? col_inc[XW-1:0] : x_cur);
		row_n      = col_wrap ? row_inc[HEIGHT_W-1:0] : y_cur;
		pend_full  = (PEND_W'(frame_cfg.width) + 1'b1) * PEND_W'(frame_cfg.channels);
		emit_px    = (y_cur >= HEIGHT_W'(BORDER)) || ((y_cur == HEIGHT_W'(1)) && (x_cur != '0));
		interior_px = (x_cur >= XW'(BORDER)) && (WIDTH_W'(x_cur) < frame_cfg.width)
			&& (y_cur >= HEIGHT_W'(BORDER));
		addr       = {x_cur, c_cur};
		wr_en      = accept && !flush;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			chan_q     <= '0;
			pend_q     <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept && (!flush || flush_go);
			if (accept) begin
				if (flush) begin
					if (flush_go) begin
						chan_q <= chan_n;
						col_q  <= col_n;
						pend_q <= pend_q - 1'b1;
					end
				end else if (row_end) begin
					row_q  <= frame_cfg.height;
					col_q  <= '0;
					chan_q <= '0;
					pend_q <= pend_full;
				end else begin
					row_q  <= row_n;
					col_q  <= col_n;
					chan_q <= chan_n;
					if (restart) begin
						pend_q <= '0;
					end
				end
			end
		end
	end

	// Bank y[0] holds the row being written; the other bank holds the row above it.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd0_s1 <= line0_q[addr];
		end
		if (wr_en && !y_cur[0]) begin
			line0_q[addr] <= pixel_value;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd1_s1 <= line1_q[addr];
		end
		if (wr_en && y_cur[0]) begin
			line1_q[addr] <= pixel_value;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bot_s1      <= flush ? '0 : pixel_value;
			top_en_s1   <= !flush && (y_cur >= HEIGHT_W'(BORDER));
			mid_en_s1   <= flush || (y_cur != '0);
			mid_bank_s1 <= flush ? ~frame_cfg.height[0] : ~y_cur[0];
			chan_s1     <= c_cur;
			emit_s1     <= flush || emit_px;
			interior_s1 <= !flush && interior_px;
			last_s1     <= flush && (pend_q == PEND_W'(1));
		end
	end

	always_comb begin
		push               = s1_valid_q;
		push_item.top      = top_en_s1 ? (mid_bank_s1 ? rd0_s1 : rd1_s1) : '0;
		push_item.mid      = mid_en_s1 ? (mid_bank_s1 ? rd1_s1 : rd0_s1) : '0;
		push_item.bot      = bot_s1;
		push_item.chan     = chan_s1;
		push_item.emit     = emit_s1;
		push_item.interior = interior_s1;
		push_item.last     = last_s1;
	end

`ifndef SYNTHESIS
	a_idle_flush_no_item: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && flush && !flush_go) |=> !s1_valid_q)
		else $error("ignored flush produced a queue item");
`endif

endmodule

// ===== hw/rtl/kconv_fifo.sv =====
// Short item queue between the front end and the convolution back end.
module kconv_fifo
	import kconv_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  kconv_item_t      push_item,
	input  logic             pop,
	output logic             avail,
	output kconv_item_t      head,
	output logic [FIFO_AW:0] level
);

	kconv_item_t          mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_AW:0]     count_q;

	assign avail = count_q != '0;
	assign head  = mem_q[rd_ptr_q];
	assign level = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && (count_q == (FIFO_AW+1)'(FIFO_DEPTH))) |-> pop)
		else $error("item queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("item queue underflow");
	a_ptr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q - rd_ptr_q) == count_q[FIFO_AW-1:0])
		else $error("item queue pointers disagree with fill count");
`endif

endmodule

// ===== hw/rtl/kconv_back.sv =====
// Back end: per-channel 3x3 windows, tap products, sum, clamp and the output register.
module kconv_back
	import kconv_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic [KERNEL_W-1:0] kernel_coeffs,
	input  logic                avail,
	input  kconv_item_t         head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [PIX_W-1:0]    result_value,
	output logic                end_of_frame
);

	logic [PIX_W-1:0] win_q [MAX_CHANNELS][3][3];

	logic                     valid_s1;
	logic signed [PROD_W-1:0] prod_s1 [3][3];
	logic [PIX_W-1:0]         center_s1;
	logic                     interior_s1;
	logic                     last_s1;

	logic                     valid_s2;
	logic signed [SUM_W-1:0]  rsum_s2 [3];
	logic [PIX_W-1:0]         center_s2;
	logic                     interior_s2;
	logic                     last_s2;

	logic                     out_valid_q;
	logic [PIX_W-1:0]         out_data_q;
	logic                     out_last_q;

	logic                        advance;
	logic [PIX_W-1:0]            nxt [3][3];
	logic signed [COEFF_BITS-1:0] tap [TAPS];
	logic signed [PROD_W-1:0]    prod [3][3];
	logic signed [SUM_W-1:0]     total;
	logic [PIX_W-1:0]            clamped;

	assign advance      = !out_valid_q || out_ready;
	assign pop          = advance && avail;
	assign out_valid    = out_valid_q;
	assign result_value = out_data_q;
	assign end_of_frame = out_last_q;

	// Window row 0 is two rows up, row 2 the current row; column 2 is the newest.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			nxt[r][0] = win_q[head.chan][r][1];
			nxt[r][1] = win_q[head.chan][r][2];
		end
		nxt[0][2] = head.top;
		nxt[1][2] = head.mid;
		nxt[2][2] = head.bot;
		for (int k = 0; k < TAPS; k++) begin
			tap[k] = kernel_coeffs[k*COEFF_BITS +: COEFF_BITS];
		end
		// True convolution: the tap for offset (i,j) meets the pixel at (x-i, y-j).
		for (int r = 0; r < 3; r++) begin
			for (int q = 0; q < 3; q++) begin
				prod[r][q] = $signed({1'b0, nxt[r][q]}) * tap[(2-q)*3 + (2-r)];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < MAX_CHANNELS; c++) begin
				for (int r = 0; r < 3; r++) begin
					for (int q = 0; q < 3; q++) begin
						win_q[c][r][q] <= '0;
					end
				end
			end
		end else if (pop) begin
			for (int r = 0; r < 3; r++) begin
				for (int q = 0; q < 3; q++) begin
					win_q[head.chan][r][q] <= nxt[r][q];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= pop && head.emit;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s1     <= prod;
			center_s1   <= nxt[1][1];
			interior_s1 <= head.interior;
			last_s1     <= head.last;
			for (int r = 0; r < 3; r++) begin
				rsum_s2[r] <= SUM_W'(prod_s1[r][0]) + SUM_W'(prod_s1[r][1])
					+ SUM_W'(prod_s1[r][2]);
			end
			center_s2   <= center_s1;
			interior_s2 <= interior_s1;
			last_s2     <= last_s1;
			out_data_q  <= interior_s2 ? clamped : center_s2;
			out_last_q  <= last_s2;
		end
	end

	always_comb begin
		total = rsum_s2[0] + rsum_s2[1] + rsum_s2[2];
		if (total < 0) begin
			clamped = '0;
		end else if (total > SUM_W'(PIX_MAX)) begin
			clamped = PIX_W'(PIX_MAX);
		end else begin
			clamped = total[PIX_W-1:0];
		end
	end

endmodule

// ===== hw/rtl/clamped_3x3_kernel_convolution_core.sv =====
// Top level of the clamped 3x3 kernel convolution core: configuration registers and wiring.
//
// The core filters a raster stream of 8-bit components (channels interleaved) with a signed
// 3x3 kernel and clamps each sum to 0..255; border pixels pass through. While the output accepts
// results, it takes one item per clock sustained, with flush items also one per clock. An
// accepted item passes the line buffer read register and the queue, then the products, row
// sums and the sum-and-clamp output register. A four-entry queue separates the line buffer
// front end from the arithmetic, so input keeps flowing while a finished result waits on the
// output. Results lag the input by one row plus one pixel; after the last pixel of a frame,
// (width + 1) * channels flush items drain the remaining results, the last one marked by
// tlast. The line buffers are two 4096-entry banks that are never cleared; rows above the
// frame never reach a result. Register writes take effect at once and belong between frames.
module clamped_3x3_kernel_convolution_core
	import kconv_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,   // [7:0] pixel_value
	input  logic                 s_axis_tuser,   // [0] flush
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [7:0]           m_axis_tdata,   // [7:0] result_value
	output logic                 m_axis_tlast,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [KERNEL_W-1:0]  cfg_data
);

	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [CHAN_W-1:0]   channels_q;
	logic [KERNEL_W-1:0] kernel_q;

	logic [WIDTH_W-1:0]  wr_width;
	logic [HEIGHT_W-1:0] wr_height;
	logic [CHAN_W-1:0]   wr_channels;

	kconv_frame_cfg_t frame_cfg;
	logic             push;
	kconv_item_t      push_item;
	logic             pop;
	logic             avail;
	kconv_item_t      head;
	logic [FIFO_AW:0] level;

	assign cfg_ready = 1'b1;

	// Registers hold the values already limited to the range the datapath supports.
	always_comb begin
		wr_width = cfg_data[WIDTH_W-1:0];
		if (wr_width < WIDTH_W'(MIN_DIM)) begin
			wr_width = WIDTH_W'(MIN_DIM);
		end else if (wr_width > WIDTH_W'(MAX_WIDTH)) begin
			wr_width = WIDTH_W'(MAX_WIDTH);
		end
		wr_height = cfg_data[HEIGHT_W-1:0];
		if (wr_height < HEIGHT_W'(MIN_DIM)) begin
			wr_height = HEIGHT_W'(MIN_DIM);
		end
		wr_channels = cfg_data[CHAN_W-1:0];
		if (wr_channels == '0) begin
			wr_channels = CHAN_W'(1);
		end else if (wr_channels > CHAN_W'(MAX_CHANNELS)) begin
			wr_channels = CHAN_W'(MAX_CHANNELS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= RST_WIDTH;
			height_q   <= RST_HEIGHT;
			channels_q <= RST_CHANNELS;
			kernel_q   <= RST_KERNEL;
		end else if (cfg_valid && cfg_ready) begin
			unique case (kconv_reg_t'(cfg_index))
				REG_WIDTH:    width_q    <= wr_width;
				REG_HEIGHT:   height_q   <= wr_height;
				REG_CHANNELS: channels_q <= wr_channels;
				REG_KERNEL:   kernel_q   <= cfg_data;
				default:      ;
			endcase
		end
	end

	assign frame_cfg.width    = width_q;
	assign frame_cfg.height   = height_q;
	assign frame_cfg.channels = channels_q;

	kconv_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pix_valid   (s_axis_tvalid),
		.pix_ready   (s_axis_tready),
		.pixel_value (s_axis_tdata),
		.flush       (s_axis_tuser),
		.frame_cfg   (frame_cfg),
		.fifo_level  (level),
		.push        (push),
		.push_item   (push_item)
	);

	kconv_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.avail     (avail),
		.head      (head),
		.level     (level)
	);

	kconv_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.kernel_coeffs (kernel_q),
		.avail         (avail),
		.head          (head),
		.pop           (pop),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.result_value  (m_axis_tdata),
		.end_of_frame  (m_axis_tlast)
	);

endmodule

// ===== tb/kconv_checker.sv =====
// Checker for the 3x3 convolution core: predicts every filtered component and compares the output.
module kconv_checker
	import kconv_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,   // [7:0] pixel_value
	input  logic                 s_axis_tuser,   // [0] flush
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic [7:0]           m_axis_tdata,   // [7:0] result_value
	input  logic                 m_axis_tlast,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [KERNEL_W-1:0]  cfg_data,
	output int unsigned          outstanding,
	output int unsigned          fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REPORT_LIMIT = 100;

	typedef struct packed {
		logic [PIX_W-1:0] value;
		logic             last;
	} pixel_result_t;

	logic [WIDTH_W-1:0]  width_reg;
	logic [HEIGHT_W-1:0] height_reg;
	logic [CHAN_W-1:0]   chan_reg;
	logic [KERNEL_W-1:0] kernel_reg;

	// Two previous rows, selected by row parity.
	logic [PIX_W-1:0] row_mem [2][MAX_WIDTH][MAX_CHANNELS];
	logic [PIX_W-1:0] window [MAX_CHANNELS][3][3];
	int unsigned col, row, chan, tail_left;

	pixel_result_t expected_results[$];

	function automatic void shift_column(input int unsigned c, input logic [PIX_W-1:0] top,
			input logic [PIX_W-1:0] mid, input logic [PIX_W-1:0] bot);
		int r;
		for (r = 0; r < 3; r++) begin
			window[c][r][0] = window[c][r][1];
			window[c][r][1] = window[c][r][2];
		end
		window[c][0][2] = top;
		window[c][1][2] = mid;
		window[c][2][2] = bot;
	endfunction

	// Advances the frame state by one item and tells whether it yields a result.
	function automatic bit filter_step(input logic [PIX_W-1:0] pix, input logic is_flush,
			output pixel_result_t res);
		int unsigned w, h, nch, x, y, c;
		logic [PIX_W-1:0] top, mid;
		logic signed [COEFF_BITS-1:0] coeff;
		int sum, i, j;
		bit emit;
		w   = width_reg < MIN_DIM ? MIN_DIM : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
		h   = height_reg < MIN_DIM ? MIN_DIM : height_reg;
		nch = chan_reg < 1 ? 1 : (chan_reg > MAX_CHANNELS ? MAX_CHANNELS : chan_reg);
		res = '0;
		if (is_flush) begin
			if (row < h || tail_left == 0) begin
				return 1'b0;
			end
			shift_column(chan, '0, row_mem[(h - 1) % 2][col][chan], '0);
			tail_left--;
			res.value = window[chan][1][1];
			res.last  = (tail_left == 0);
			chan++;
			if (chan >= nch) begin
				chan = 0;
				col++;
				if (col >= w) begin
					col = 0;
				end
			end
			return 1'b1;
		end

		// A pixel after a finished frame starts the next one, dropping any undrained tail.
		if (row >= h) begin
			col = 0;
			row = 0;
			chan = 0;
			tail_left = 0;
		end
		x = col;
		y = row;
		c = chan;
		top = y >= 2 ? row_mem[y % 2][x][c] : '0;
		mid = y >= 1 ? row_mem[(y + 1) % 2][x][c] : '0;
		shift_column(c, top, mid, pix);
		row_mem[y % 2][x][c] = pix;
		emit = y >= 2 || (y == 1 && x >= 1);
		if (emit) begin
			if (x >= BORDER && y >= BORDER && y <= h - 1) begin
				sum = 0;
				for (i = -1; i <= 1; i++) begin
					for (j = -1; j <= 1; j++) begin
						coeff = kernel_reg[COEFF_BITS * ((i + 1) * 3 + (j + 1)) +: COEFF_BITS];
						sum += int'(coeff) * int'(window[c][1 - j][1 - i]);
					end
				end
				if (sum < 0) begin
					res.value = '0;
				end else if (sum > PIX_MAX) begin
					res.value = PIX_W'(PIX_MAX);
				end else begin
					res.value = PIX_W'(sum);
				end
			end else begin
				res.value = window[c][1][1];
			end
		end
		chan++;
		if (chan >= nch) begin
			chan = 0;
			col++;
			if (col >= w) begin
				col = 0;
				row++;
			end
		end
		if (row >= h) begin
			row = h;
			col = 0;
			chan = 0;
			tail_left = (w + 1) * nch;
		end
		return emit;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		pixel_result_t want, got;
		int c, r, k;
		if (!arst_n) begin
			width_reg  = RST_WIDTH;
			height_reg = RST_HEIGHT;
			chan_reg   = RST_CHANNELS;
			kernel_reg = RST_KERNEL;
			for (c = 0; c < MAX_CHANNELS; c++) begin
				for (r = 0; r < 3; r++) begin
					for (k = 0; k < 3; k++) begin
						window[c][r][k] = '0;
					end
				end
			end
			col = 0;
			row = 0;
			chan = 0;
			tail_left = 0;
			expected_results.delete();
			outstanding = 0;
			fail_count = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.value = m_axis_tdata;
				got.last  = m_axis_tlast;
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT) begin
						$display("%0t: result with none expected: value %0d last %0b",
							$time, got.value, got.last);
					end
				end else begin
					want = expected_results.pop_front();
					if (got.value !== want.value || got.last !== want.last) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT) begin
							$display("%0t: expected value %0d last %0b, got value %0d last %0b",
								$time, want.value, want.last, got.value, got.last);
						end
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WIDTH:    width_reg  = cfg_data[WIDTH_W-1:0];
					REG_HEIGHT:   height_reg = cfg_data[HEIGHT_W-1:0];
					REG_CHANNELS: chan_reg   = cfg_data[CHAN_W-1:0];
					REG_KERNEL:   kernel_reg = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (filter_step(s_axis_tdata, s_axis_tuser, want)) begin
					expected_results.push_back(want);
				end
			end
			outstanding = expected_results.size();
		end
	end

endmodule

// ===== tb/tb_clamped_3x3_kernel_convolution_core.sv =====
// Testbench top for the 3x3 convolution core: clock, reset, stimulus and verdict.
module tb_clamped_3x3_kernel_convolution_core;
	timeunit 1ns;
	timeprecision 1ps;
	import kconv_pkg::*;

	localparam int ITEM_TARGET    = 1950;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 20;

	localparam logic [COEFF_BITS-1:0] COEFF_MIN = {1'b1, {(COEFF_BITS - 1){1'b0}}};
	localparam logic [COEFF_BITS-1:0] COEFF_MAX = {1'b0, {(COEFF_BITS - 1){1'b1}}};

	typedef enum int {
		K_RANDOM,
		K_MIN,
		K_MAX,
		K_IDENTITY,
		K_SMALL,
		K_NORTH
	} kernel_style_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata = '0;   // [7:0] pixel_value
	logic                 s_axis_tuser = 1'b0; // [0] flush
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [7:0]           m_axis_tdata;        // [7:0] result_value
	logic                 m_axis_tlast;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [KERNEL_W-1:0]  cfg_data = '0;

	int unsigned outstanding;
	int unsigned fail_count;
	int unsigned items_sent = 0;
	int unsigned send_idle_pct = 22;
	int unsigned recv_idle_pct = 51;
	int unsigned quiet_cycles = 0;
	bit          mid_pause_done = 1'b0;

	clamped_3x3_kernel_convolution_core i_dut (.*);

	kconv_checker i_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Ends the run when no channel has moved an item for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [PIX_W-1:0] pick_pixel();
		case ($urandom_range(9))
			0: return '0;
			1: return PIX_W'(PIX_MAX);
			default: return PIX_W'($urandom);
		endcase
	endfunction

	function automatic logic [KERNEL_W-1:0] pick_kernel();
		logic [KERNEL_W-1:0] k;
		kernel_style_t style;
		int t;
		style = kernel_style_t'($urandom_range(K_NORTH));
		k = KERNEL_W'({$urandom, $urandom});
		for (t = 0; t < TAPS; t++) begin
			case (style)
				K_MIN:      k[t * COEFF_BITS +: COEFF_BITS] = COEFF_MIN;
				K_MAX:      k[t * COEFF_BITS +: COEFF_BITS] = COEFF_MAX;
				K_IDENTITY: k[t * COEFF_BITS +: COEFF_BITS] = (t == TAPS / 2) ? 1 : 0;
				K_SMALL:    k[t * COEFF_BITS +: COEFF_BITS] = COEFF_BITS'($urandom_range(2) - 1);
				default: ;
			endcase
		end
		if (style == K_NORTH) begin
			k = RST_KERNEL;
		end
		return k;
	endfunction

	// Leaves tvalid high after the accepting edge so that items can follow back to back.
	task automatic send_item(input logic [PIX_W-1:0] pix, input logic is_flush);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pix;
		s_axis_tuser  <= is_flush;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
		if (items_sent == ITEM_TARGET / 3) begin
			send_idle_pct = 51;
			recv_idle_pct = 22;
		end else if (items_sent == 2 * ITEM_TARGET / 3) begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
	endtask

	task automatic write_reg(input kconv_reg_t idx, input logic [KERNEL_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic program_core(input logic [KERNEL_W-1:0] w, input logic [KERNEL_W-1:0] h,
			input logic [KERNEL_W-1:0] nch, input logic [KERNEL_W-1:0] k);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_CHANNELS, nch);
		write_reg(REG_KERNEL, k);
		cfg_valid <= 1'b0;
	endtask

	// Stops sending until every predicted result has left the core, then lets the pipe empty.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_frame(input int w, input int h, input int nch, input bit drain_all);
		int total, tail, n;
		total = w * h * nch;
		tail = (w + 1) * nch;
		for (n = 0; n < total; n++) begin
			// Flush items inside a frame are ignored by the core.
			if (n > 0 && $urandom_range(99) < 3) begin
				send_item(pick_pixel(), 1'b1);
			end
			if (!mid_pause_done && items_sent > 100 && n == total / 2) begin
				drain_results();
				mid_pause_done = 1'b1;
			end
			send_item(pick_pixel(), 1'b0);
		end
		if (!drain_all) begin
			tail = $urandom_range(tail - 1);
		end
		for (n = 0; n < tail; n++) begin
			send_item(pick_pixel(), 1'b1);
		end
		if (drain_all && $urandom_range(3) == 0) begin
			send_item(pick_pixel(), 1'b1);
		end
	endtask

	initial begin
		int n, f, frames;
		int unsigned w_reg, h_reg, ch_reg, w_eff, h_eff, ch_eff;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Register extremes first, then a 3x3 single channel frame with the largest taps.
		write_reg(REG_WIDTH, KERNEL_W'(2047));
		write_reg(REG_HEIGHT, KERNEL_W'(65535));
		write_reg(REG_CHANNELS, KERNEL_W'(7));
		write_reg(REG_KERNEL, '1);
		program_core(3, 3, 1, {TAPS{COEFF_MAX}});

		send_item('0, 1'b1);
		for (n = 0; n < 9; n++) begin
			send_item(n % 2 ? '0 : PIX_W'(PIX_MAX), 1'b0);
			if (n == 4) begin
				send_item(PIX_W'(PIX_MAX), 1'b1);
			end
		end
		// Part of the tail only: the next pixel starts a new frame.
		send_item('0, 1'b1);
		send_item(PIX_W'(PIX_MAX), 1'b1);
		for (n = 0; n < 9; n++) begin
			send_item(n == 4 ? '0 : PIX_W'(PIX_MAX), 1'b0);
		end
		for (n = 0; n < 5; n++) begin
			send_item(PIX_W'(n * 60), 1'b1);
		end

		while (items_sent < ITEM_TARGET) begin
			drain_results();
			case ($urandom_range(9))
				0: w_reg = $urandom_range(2);
				1: w_reg = $urandom_range(11, 24);
				default: w_reg = $urandom_range(3, 10);
			endcase
			h_reg = $urandom_range(99) < 15 ? $urandom_range(2) : $urandom_range(3, 6);
			ch_reg = $urandom_range(99) < 30 ? $urandom_range(7) : $urandom_range(1, 4);
			w_eff = w_reg < MIN_DIM ? MIN_DIM : (w_reg > MAX_WIDTH ? MAX_WIDTH : w_reg);
			h_eff = h_reg < MIN_DIM ? MIN_DIM : h_reg;
			ch_eff = ch_reg < 1 ? 1 : (ch_reg > MAX_CHANNELS ? MAX_CHANNELS : ch_reg);
			program_core(w_reg, h_reg, ch_reg, pick_kernel());
			frames = $urandom_range(1, 3);
			for (f = 0; f < frames; f++) begin
				send_frame(w_eff, h_eff, ch_eff, f == frames - 1 || $urandom_range(3) != 0);
			end
		end

		// One frame at the full line buffer width, reached through an oversized register value.
		drain_results();
		program_core(2047, 2, 1, pick_kernel());
		send_frame(MAX_WIDTH, MIN_DIM, 1, 1'b1);

		drain_results();
		if (fail_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
